>>> design/rpfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfp_pkg
// Shared types and constants of the rgba pixel format packer.
// ----------------------------------------------------------------------------
package rpfp_pkg;

   // pixel format codes
   typedef enum logic [3:0] {
      FMT_1BIT       = 4'd0,
      FMT_2BIT       = 4'd1,
      FMT_4BIT       = 4'd2,
      FMT_8BIT       = 4'd3,
      FMT_16BIT      = 4'd4,
      FMT_24BIT      = 4'd5,
      FMT_32BIT      = 4'd6,
      FMT_32ALPHA    = 4'd7,
      FMT_32PREMUL   = 4'd8
   } fmt_type;

   // register indexes of the configuration port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_FORMAT     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MSB_FIRST        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_PALETTE      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_POSITIONS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_MASKS    = 3'd4;

   localparam int unsigned CSR_DATA_W = 48;

   typedef struct packed {
      logic [3:0]  pixel_format;
      logic        msb_first;
      logic        use_palette;
      logic [15:0] channel_positions;
      logic [47:0] channel_masks;
   } cfg_type;

   typedef struct packed {
      logic [7:0] palette_index;
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // bytes of one pixel, bytes[0] goes out first
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
      logic            last;
   } conv_result_type;

endpackage

>>> design/rpfp_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfp_convert
// Converts one registered pixel into up to four packed bytes and keeps the
// sub-byte packing state.
// ----------------------------------------------------------------------------
module rpfp_convert import rpfp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  pixel_type       pix,
   input  logic            row_end,
   input  cfg_type         cfg,
   output conv_result_type result
);

   logic [7:0]  acc_ff, acc_in;
   logic [2:0]  pib_ff, pib_in;
   logic [15:0] recip_tab [256];

   // reciprocal table for un-premultiplying, entry i is 65280 / i
   assign recip_tab[0] = 16'd0;
   for (genvar gi = 1; gi < 256; gi++) begin : g_recip
      localparam logic [15:0] Recip = 16'(65280 / gi);
      assign recip_tab[gi] = Recip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         pib_ff <= '0;
      end else if (advance) begin
         acc_ff <= acc_in;
         pib_ff <= pib_in;
      end
   end

   always_comb begin
      logic [15:0] gray_sum;
      logic [7:0]  gray;
      logic [15:0] um;
      logic [23:0] prod_r, prod_g, prod_b;
      logic [3:0]  nr, ng, nb, na;
      logic [3:0]  plen;
      logic [7:0]  sub_v;
      logic [2:0]  sub_pos;
      logic [2:0]  sub_sh;
      logic        sub_full;
      logic [7:0]  acc_new;
      logic [15:0] w;
      logic        sub_mode;

      gray_sum = 16'({8'd0, pix.red} * 16'd77) + 16'({8'd0, pix.green} * 16'd151)
               + 16'({8'd0, pix.blue} * 16'd28);
      gray     = gray_sum[15:8];
      um       = recip_tab[pix.alpha];
      prod_r   = 24'(um) * 24'(pix.red);
      prod_g   = 24'(um) * 24'(pix.green);
      prod_b   = 24'(um) * 24'(pix.blue);
      nr = cfg.channel_positions[3:0];
      ng = cfg.channel_positions[7:4];
      nb = cfg.channel_positions[11:8];
      na = cfg.channel_positions[15:12];

      sub_v    = '0;
      sub_pos  = '0;
      sub_sh   = '0;
      sub_full = 1'b0;
      sub_mode = 1'b0;
      plen     = 4'd4;
      w        = '0;

      result.bytes = '0;
      result.count = '0;
      result.last  = row_end;
      acc_in       = '0;
      pib_in       = '0;

      case (cfg.pixel_format)
         FMT_1BIT: begin
            sub_mode = 1'b1;
            sub_v    = {7'd0, cfg.use_palette ? pix.palette_index[0] : pix.green[7]};
            sub_pos  = pib_ff;
            sub_sh   = cfg.msb_first ? 3'd7 - sub_pos : sub_pos;
            sub_full = (sub_pos == 3'd7);
         end
         FMT_2BIT: begin
            sub_mode = 1'b1;
            sub_v    = {6'd0, cfg.use_palette ? pix.palette_index[1:0] : pix.green[7:6]};
            sub_pos  = {1'b0, pib_ff[1:0]};
            sub_sh   = cfg.msb_first ? 3'd6 - {sub_pos[1:0], 1'b0} : {sub_pos[1:0], 1'b0};
            sub_full = (sub_pos[1:0] == 2'd3);
         end
         FMT_4BIT: begin
            sub_mode = 1'b1;
            sub_v    = {4'd0, cfg.use_palette ? pix.palette_index[3:0] : gray[7:4]};
            sub_pos  = {2'd0, pib_ff[0]};
            sub_sh   = cfg.msb_first ? 3'd4 - {pib_ff[0], 2'd0} : {pib_ff[0], 2'd0};
            sub_full = pib_ff[0];
         end
         FMT_8BIT: begin
            result.bytes[0] = cfg.use_palette ? pix.palette_index : gray;
            result.count    = 3'd1;
         end
         FMT_16BIT: begin
            w = (({pix.red, 8'h00} >> nr) & cfg.channel_masks[15:0])
              | (({pix.green, 8'h00} >> ng) & cfg.channel_masks[31:16])
              | (({pix.blue, 8'h00} >> nb) & cfg.channel_masks[47:32]);
            result.bytes[0] = cfg.msb_first ? w[15:8] : w[7:0];
            result.bytes[1] = cfg.msb_first ? w[7:0] : w[15:8];
            result.count    = 3'd2;
         end
         FMT_24BIT, FMT_32BIT, FMT_32PREMUL: begin
            plen = (cfg.pixel_format == FMT_24BIT) ? 4'd3 : 4'd4;
            if (nr < plen) result.bytes[nr[1:0]] = pix.red;
            if (ng < plen) result.bytes[ng[1:0]] = pix.green;
            if (nb < plen) result.bytes[nb[1:0]] = pix.blue;
            if (cfg.pixel_format == FMT_32PREMUL && na < plen)
               result.bytes[na[1:0]] = pix.alpha;
            result.count = plen[2:0];
         end
         FMT_32ALPHA: begin
            // alpha first, colours may overwrite it
            if (na < plen) result.bytes[na[1:0]] = pix.alpha;
            if (nr < plen) result.bytes[nr[1:0]] = prod_r[15:8];
            if (ng < plen) result.bytes[ng[1:0]] = prod_g[15:8];
            if (nb < plen) result.bytes[nb[1:0]] = prod_b[15:8];
            result.count = 3'd4;
         end
         default: begin
            // unused codes: nothing out, packer state untouched
            acc_in = acc_ff;
            pib_in = pib_ff;
         end
      endcase

      acc_new = acc_ff | 8'(sub_v << sub_sh);
      if (sub_mode) begin
         if (sub_full || row_end) begin
            result.bytes[0] = acc_new;
            result.count    = 3'd1;
         end else begin
            acc_in = acc_new;
            pib_in = sub_pos + 3'd1;
         end
      end
   end

endmodule

>>> design/rpfp_byte_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfp_byte_out
// Result register for one pixel's bytes, sent one beat at a time.
// ----------------------------------------------------------------------------
module rpfp_byte_out import rpfp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  conv_result_type result,
   output logic            free,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [7:0]      rsp_tdata,   // data_byte[7:0]
   output logic            rsp_tlast
);

   logic            valid_ff, valid_in;
   logic [3:0][7:0] bytes_ff;
   logic [1:0]      cnt_m1_ff;
   logic            last_ff;
   logic [1:0]      idx_ff, idx_in;
   logic            final_beat;

   assign final_beat = (idx_ff == cnt_m1_ff);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = bytes_ff[idx_ff];
   assign rsp_tlast  = last_ff && final_beat;
   assign free       = !valid_ff || (rsp_tready && final_beat);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (valid_ff && rsp_tready) begin
         if (final_beat) begin
            valid_in = 1'b0;
            idx_in   = '0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff  <= result.bytes;
         cnt_m1_ff <= 2'(result.count - 3'd1);
         last_ff   <= result.last;
      end
   end

endmodule

>>> design/rgba_pixel_format_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_pixel_format_packer
// Packs RGBA pixels into a byte stream in the configured raster format.
// ----------------------------------------------------------------------------
// One pixel per req_ beat, with req_tlast marking the last pixel of a row.
// Packed bytes leave one per rsp_ beat; rsp_tlast is set on the last byte
// emitted for a pixel that ends its row (a partial sub-byte is flushed then).
// The csr_ port writes one register per cycle. The user must use it only
// while idle; the block itself does not enforce this. A pixel is registered
// in the input register, converted in a single combinational pass and
// registered again in the result register, which offers its first byte.
// A pixel yields 0 to 4 bytes and the result register sends one byte a
// cycle while rsp_tready is high, so throughput is one pixel per cycle in
// 1/2/4/8-bit modes; in the 16-, 24- and 32-bit modes the byte-wide output
// sets it, with 2, 3 or 4 bytes per pixel.
// The next pixel is converted during the last beat of the previous one.
// When the receiver stalls the result register holds, the input register
// fills and req_tready drops. Reset clears both registers, the packing
// state and the configuration (8-bit format, everything else zero).
// ----------------------------------------------------------------------------
module rgba_pixel_format_packer import rpfp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [39:0]            req_tdata,   // red, green, blue, alpha, palette_index
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // data_byte
   output logic                   rsp_tlast,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   cfg_type         cfg_ff;
   logic            in_valid_ff;
   pixel_type       pix_ff;
   logic            row_end_ff;
   logic            advance;
   logic            out_free;
   conv_result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_format      <= FMT_8BIT;
         cfg_ff.msb_first         <= 1'b0;
         cfg_ff.use_palette       <= 1'b0;
         cfg_ff.channel_positions <= '0;
         cfg_ff.channel_masks     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PIXEL_FORMAT:      cfg_ff.pixel_format      <= csr_wr_data[3:0];
            CSR_MSB_FIRST:         cfg_ff.msb_first         <= csr_wr_data[0];
            CSR_USE_PALETTE:       cfg_ff.use_palette       <= csr_wr_data[0];
            CSR_CHANNEL_POSITIONS: cfg_ff.channel_positions <= csr_wr_data[15:0];
            CSR_CHANNEL_MASKS:     cfg_ff.channel_masks     <= csr_wr_data[47:0];
            default: ;
         endcase
      end
   end

   // pixels with no bytes move on without the result register
   assign advance    = in_valid_ff && (result.count == 3'd0 || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         pix_ff     <= pixel_type'(req_tdata);
         row_end_ff <= req_tlast;
      end
   end

   rpfp_convert u_convert (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .pix     (pix_ff),
      .row_end (row_end_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   rpfp_byte_out u_byte_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && result.count != 3'd0),
      .result     (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
